### hw/rtl/chr_pkg.sv
package chr_pkg;

	localparam int RING_ENTRIES = 1024;
	localparam int RING_AW      = $clog2(RING_ENTRIES);
	localparam int CNT_W        = RING_AW + 1;
	localparam int SERVERS      = 64;
	localparam int SRV_W        = $clog2(SERVERS);

	localparam int KEY_W  = 32;
	localparam int WGT_W  = 12;
	localparam int CUM_W  = 20;
	localparam int LOAD_W = 20;
	localparam int BF_W   = 16;

	// shared divider: widest dividend is (wb + w) * r, 41 bits
	localparam int DIV_NW = 42;
	localparam int DIV_DW = 20;
	localparam int DIV_CW = $clog2(DIV_NW);

	// slot total fits in 30 bits for the largest load and balance factor
	localparam int TOT_W = 30;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_RECORD = 2'd2;
	localparam logic [1:0] CMD_LOOKUP = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam logic CFG_BALANCE = 1'b0;
	localparam logic CFG_TOTAL_W = 1'b1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [KEY_W-1:0]  key;
		logic [SRV_W-1:0]  server_id;
		logic [WGT_W-1:0]  weight;
		logic [CUM_W-1:0]  weight_before;
		logic [LOAD_W-1:0] server_load;
		logic [SRV_W-1:0]  avoid_server;
		logic              avoid_enable;
		logic [LOAD_W-1:0] total_load;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [SRV_W-1:0] chosen_server;
		logic             chosen_valid;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [SRV_W-1:0] owner;
	} ring_entry_t;

	typedef struct packed {
		logic [WGT_W-1:0]  weight;
		logic [CUM_W-1:0]  weight_before;
		logic [LOAD_W-1:0] busy;
	} srv_rec_t;

endpackage

### hw/rtl/chr_ring_mem.sv
module chr_ring_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [chr_pkg::RING_AW-1:0]  waddr,
	input  chr_pkg::ring_entry_t         wdata,
	input  logic [chr_pkg::RING_AW-1:0]  raddr,
	output chr_pkg::ring_entry_t         rdata
);
	import chr_pkg::*;

	ring_entry_t mem [RING_ENTRIES];
	ring_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

### hw/rtl/chr_srv_tbl.sv
module chr_srv_tbl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [chr_pkg::SRV_W-1:0]  waddr,
	input  chr_pkg::srv_rec_t          wdata,
	input  logic [chr_pkg::SRV_W-1:0]  raddr,
	output chr_pkg::srv_rec_t          rdata
);
	import chr_pkg::*;

	srv_rec_t           mem [SERVERS];
	logic [SERVERS-1:0] vld_q;
	srv_rec_t           rd_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// never-written records read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

### hw/rtl/chr_div.sv
module chr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [chr_pkg::DIV_NW-1:0]  num,
	input  logic [chr_pkg::DIV_DW-1:0]  den,
	output logic                        done,
	output logic [chr_pkg::DIV_NW-1:0]  quo,
	output logic [chr_pkg::DIV_DW-1:0]  rem
);
	import chr_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   rem_sh;
	logic [DIV_DW:0]   rem_sub;
	logic              take;

	// restoring division, one quotient bit a cycle
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_NW-1]};
		take    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - DIV_CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### hw/rtl/consistent_hash_ring_bounded_load.sv
// operation: insert shifts entries above the new key up, remove scans for the key and shifts
//   later entries down, record writes the server table, lookup scans for the successor and,
//   when balance_factor is non-zero, finds the slot quota and divides for each candidate
// throughput: one item at a time; the ring memory port and the bit-serial divider set it
// reset: ring empty, server records read as zero, balance_factor 0, total_weight 1;
//   no clearing pass, the server table uses per-entry valid flops
module consistent_hash_ring_bounded_load (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  chr_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output chr_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [chr_pkg::CUM_W-1:0]     cfg_data
);
	import chr_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_INS_RD  = 5'd1;
	localparam logic [4:0] S_INS_CMP = 5'd2;
	localparam logic [4:0] S_RM_RD   = 5'd3;
	localparam logic [4:0] S_RM_CMP  = 5'd4;
	localparam logic [4:0] S_RM_SH   = 5'd5;
	localparam logic [4:0] S_RM_SW   = 5'd6;
	localparam logic [4:0] S_REC     = 5'd7;
	localparam logic [4:0] S_LK_RD   = 5'd8;
	localparam logic [4:0] S_LK_CMP  = 5'd9;
	localparam logic [4:0] S_LK_RDN  = 5'd10;
	localparam logic [4:0] S_LK_RDP  = 5'd11;
	localparam logic [4:0] S_LK_SEL  = 5'd12;
	localparam logic [4:0] S_TOT_GO  = 5'd13;
	localparam logic [4:0] S_TOT_W   = 5'd14;
	localparam logic [4:0] S_Q_GO    = 5'd15;
	localparam logic [4:0] S_Q_W     = 5'd16;
	localparam logic [4:0] S_CHK     = 5'd17;
	localparam logic [4:0] S_TB      = 5'd18;
	localparam logic [4:0] S_DA_GO   = 5'd19;
	localparam logic [4:0] S_DA_W    = 5'd20;
	localparam logic [4:0] S_DB_GO   = 5'd21;
	localparam logic [4:0] S_DB_W    = 5'd22;
	localparam logic [4:0] S_ADV     = 5'd23;
	localparam logic [4:0] S_ADV_RD  = 5'd24;
	localparam logic [4:0] S_FIN     = 5'd25;
	localparam logic [4:0] S_TOT_FIN = 5'd26;

	// reciprocals of 100 for the slot total: 2^28/100 and 2^30/100 rounded up
	localparam int         TL_W     = LOAD_W + 1;
	localparam logic [21:0] RCP100_X = 22'd2684355;
	localparam logic [23:0] RCP100_Y = 24'd10737419;

	logic [4:0] state_q;

	// configuration
	logic [BF_W-1:0]  bf_q;
	logic [CUM_W-1:0] tw_q;
	logic [CUM_W-1:0] tw_eff;

	// latched item
	in_item_t         it_q;

	// ring bookkeeping
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   i_q;
	logic [RING_AW-1:0] nx_q;
	logic [RING_AW-1:0] pv_idx;
	logic [KEY_W-1:0]   keyn_q;
	logic [SRV_W-1:0]   ownn_q;
	logic [RING_AW-1:0] idx_q;
	logic [SRV_W-1:0]   srv_q;
	logic               wraps_q;

	// slot total: (load + 1) split as 100 * hi + lo, then each part scaled by the factor
	logic [TL_W-1:0]    tl_inc;
	logic [42:0]        x_prod;
	logic [TL_W-1:0]    lo_w;
	logic [46:0]        y_prod;
	logic [14:0]        hq_q;
	logic [22:0]        y_q;
	logic [TOT_W-1:0]   ab_q;

	// bounded-load arithmetic
	logic [TOT_W-1:0]   tot_q;
	logic [TOT_W-1:0]   qv_q;
	logic [DIV_DW-1:0]  r_q;
	logic [DIV_NW-1:0]  wq_q;
	logic [DIV_NW-1:0]  pa_q;
	logic [DIV_NW-1:0]  pb_q;
	logic [DIV_NW-1:0]  da_q;
	logic [LOAD_W-1:0]  busy_q;
	logic [DIV_NW:0]    slots;
	logic               eligible;

	// result staging and output register
	out_item_t  res_q;
	out_item_t  out_q;
	logic       out_vld_q;
	logic [1:0] acc_status;

	// memory and divider hookups
	logic               rm_we;
	logic [RING_AW-1:0] rm_waddr;
	ring_entry_t        rm_wdata;
	logic [RING_AW-1:0] rm_raddr;
	ring_entry_t        rm_rd;
	srv_rec_t           tb_rd;
	srv_rec_t           tb_wdata;
	logic               div_start;
	logic [DIV_NW-1:0]  div_num;
	logic [DIV_DW-1:0]  div_den;
	logic               div_done;
	logic [DIV_NW-1:0]  div_quo;
	logic [DIV_DW-1:0]  div_rem;

	logic [CNT_W-1:0]   adv_next;
	logic               adv_wrap;
	logic [KEY_W-1:0]   dp;
	logic [KEY_W-1:0]   dn;
	logic               in_acc;
	logic               out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_vld_q || !out_stall;
	assign tw_eff   = (tw_q == '0) ? CUM_W'(1) : tw_q;

	// predecessor of the successor, wrapping to the last entry
	assign pv_idx = (nx_q == '0) ? RING_AW'(count_q - CNT_W'(1)) : nx_q - RING_AW'(1);

	assign adv_next = CNT_W'(idx_q) + CNT_W'(1);
	assign adv_wrap = adv_next >= count_q;

	// distances on the 32-bit circle
	assign dp = it_q.key - rm_rd.key;
	assign dn = keyn_q - it_q.key;

	// ceil((load + 1) * factor / 100) = hi * factor + floor((lo * factor + 99) / 100)
	assign tl_inc = {1'b0, it_q.total_load} + TL_W'(1);
	assign x_prod = 43'(tl_inc) * 43'(RCP100_X);
	assign lo_w   = tl_inc - TL_W'(hq_q) * TL_W'(100);
	assign y_prod = 47'(y_q) * 47'(RCP100_Y);

	// quota: w*q + floor((wb+w)*r/tw) - floor(wb*r/tw), zero counts as one
	assign slots    = {1'b0, wq_q} + {1'b0, da_q} - {1'b0, div_quo};
	assign eligible = (slots == '0) ? (busy_q == '0) : ({{(DIV_NW+1-LOAD_W){1'b0}}, busy_q} < slots);

	assign tb_wdata = '{weight: it_q.weight, weight_before: it_q.weight_before,
	                    busy: it_q.server_load};

	// full-ring and empty-ring status known when the item is taken
	always_comb begin
		acc_status = ST_DONE;
		if (in_data.cmd == CMD_INSERT && count_q >= CNT_W'(RING_ENTRIES)) begin
			acc_status = ST_FULL;
		end
		if (in_data.cmd == CMD_LOOKUP && count_q == '0) begin
			acc_status = ST_ABSENT;
		end
	end

	always_comb begin
		rm_we     = 1'b0;
		rm_waddr  = i_q[RING_AW-1:0];
		rm_wdata  = '{key: it_q.key, owner: it_q.server_id};
		rm_raddr  = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = tw_eff;
		case (state_q)
			S_INS_RD: begin
				if (i_q == '0) begin
					rm_we = 1'b1;
				end else begin
					rm_raddr = RING_AW'(i_q - CNT_W'(1));
				end
			end
			S_INS_CMP: begin
				rm_we = 1'b1;
				// keys above the new one move up a place, equal keys stay in front
				if (rm_rd.key > it_q.key) begin
					rm_wdata = rm_rd;
				end
			end
			S_RM_RD:  rm_raddr = i_q[RING_AW-1:0];
			S_RM_SH:  rm_raddr = RING_AW'(i_q + CNT_W'(1));
			S_RM_SW: begin
				rm_we    = 1'b1;
				rm_wdata = rm_rd;
			end
			S_LK_RD:  rm_raddr = i_q[RING_AW-1:0];
			S_LK_RDN: rm_raddr = nx_q;
			S_LK_RDP: rm_raddr = pv_idx;
			S_Q_GO: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(tot_q);
			end
			S_DA_GO: begin
				div_start = 1'b1;
				div_num   = pa_q;
			end
			S_DB_GO: begin
				div_start = 1'b1;
				div_num   = pb_q;
			end
			S_ADV:    rm_raddr = adv_wrap ? '0 : adv_next[RING_AW-1:0];
			default: begin
			end
		endcase
	end

	chr_ring_mem u_ring (
		.clk   (clk),
		.we    (rm_we),
		.waddr (rm_waddr),
		.wdata (rm_wdata),
		.raddr (rm_raddr),
		.rdata (rm_rd)
	);

	chr_srv_tbl u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (state_q == S_REC),
		.waddr  (it_q.server_id),
		.wdata  (tb_wdata),
		.raddr  (srv_q),
		.rdata  (tb_rd)
	);

	chr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q <= '0;
			tw_q <= CUM_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BALANCE: bf_q <= cfg_data[BF_W-1:0];
				CFG_TOTAL_W: tw_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			i_q       <= '0;
			wraps_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						i_q <= '0;
						case (in_data.cmd)
							CMD_INSERT: begin
								if (count_q >= CNT_W'(RING_ENTRIES)) begin
									state_q <= S_FIN;
								end else begin
									i_q     <= count_q;
									state_q <= S_INS_RD;
								end
							end
							CMD_REMOVE: state_q <= S_RM_RD;
							CMD_RECORD: state_q <= S_REC;
							CMD_LOOKUP: state_q <= (count_q == '0) ? S_FIN : S_LK_RD;
							default:    state_q <= S_FIN;
						endcase
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rm_rd.key > it_q.key) begin
						i_q     <= i_q - CNT_W'(1);
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_RM_RD:  state_q <= (i_q == count_q) ? S_FIN : S_RM_CMP;
				S_RM_CMP: begin
					if (rm_rd.key == it_q.key) begin
						state_q <= S_RM_SH;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_RM_RD;
					end
				end
				S_RM_SH: begin
					if (i_q + CNT_W'(1) >= count_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_RM_SW;
					end
				end
				S_RM_SW: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_RM_SH;
				end
				S_REC:    state_q <= S_FIN;
				S_LK_RD:  state_q <= (i_q == count_q) ? S_LK_RDN : S_LK_CMP;
				S_LK_CMP: begin
					if (rm_rd.key < it_q.key) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_LK_RD;
					end else begin
						state_q <= S_LK_RDN;
					end
				end
				S_LK_RDN: state_q <= S_LK_RDP;
				S_LK_RDP: state_q <= S_LK_SEL;
				S_LK_SEL: begin
					wraps_q <= 1'b0;
					state_q <= (bf_q != '0) ? S_TOT_GO : S_CHK;
				end
				S_TOT_GO:  state_q <= S_TOT_W;
				S_TOT_W:   state_q <= S_TOT_FIN;
				S_TOT_FIN: state_q <= S_Q_GO;
				S_Q_GO:    state_q <= S_Q_W;
				S_Q_W:     state_q <= div_done ? S_CHK : S_Q_W;
				S_CHK: begin
					if (it_q.avoid_enable && srv_q == it_q.avoid_server) begin
						state_q <= S_ADV;
					end else if (bf_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_TB;
					end
				end
				S_TB:     state_q <= S_DA_GO;
				S_DA_GO:  state_q <= S_DA_W;
				S_DA_W:   state_q <= div_done ? S_DB_GO : S_DA_W;
				S_DB_GO:  state_q <= S_DB_W;
				S_DB_W: begin
					if (div_done) begin
						state_q <= eligible ? S_FIN : S_ADV;
					end
				end
				S_ADV: begin
					// second wrap ends the walk on the last server examined
					if (adv_wrap && wraps_q) begin
						state_q <= S_FIN;
					end else begin
						wraps_q <= wraps_q | adv_wrap;
						state_q <= S_ADV_RD;
					end
				end
				S_ADV_RD: state_q <= S_CHK;
				S_FIN: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			it_q  <= in_data;
			res_q <= '{status: acc_status, chosen_server: '0, chosen_valid: 1'b0};
		end
		case (state_q)
			S_RM_RD: begin
				if (i_q == count_q) begin
					res_q.status <= ST_ABSENT;
				end
			end
			S_LK_RD: begin
				if (i_q == count_q) begin
					nx_q <= '0;
				end
			end
			S_LK_CMP: begin
				if (!(rm_rd.key < it_q.key)) begin
					nx_q <= i_q[RING_AW-1:0];
				end
			end
			S_LK_SEL: begin
				if (dp <= dn) begin
					idx_q <= pv_idx;
					srv_q <= rm_rd.owner;
				end else begin
					idx_q <= nx_q;
					srv_q <= ownn_q;
				end
			end
			S_LK_RDP: begin
				keyn_q <= rm_rd.key;
				ownn_q <= rm_rd.owner;
			end
			S_TOT_GO: hq_q <= x_prod[42:28];
			S_TOT_W: begin
				y_q  <= 23'(lo_w) * 23'(bf_q) + 23'd99;
				ab_q <= TOT_W'(hq_q) * TOT_W'(bf_q);
			end
			S_TOT_FIN: tot_q <= ab_q + TOT_W'(y_prod[46:30]);
			S_Q_W: begin
				if (div_done) begin
					qv_q <= div_quo[TOT_W-1:0];
					r_q  <= div_rem;
				end
			end
			S_TB: begin
				wq_q   <= DIV_NW'(tb_rd.weight) * DIV_NW'(qv_q);
				pa_q   <= (DIV_NW'(tb_rd.weight_before) + DIV_NW'(tb_rd.weight)) * DIV_NW'(r_q);
				pb_q   <= DIV_NW'(tb_rd.weight_before) * DIV_NW'(r_q);
				busy_q <= tb_rd.busy;
			end
			S_DA_W: begin
				if (div_done) begin
					da_q <= div_quo;
				end
			end
			S_ADV: begin
				if (!(adv_wrap && wraps_q)) begin
					idx_q <= adv_wrap ? '0 : adv_next[RING_AW-1:0];
				end
			end
			S_ADV_RD: srv_q <= rm_rd.owner;
			S_FIN: begin
				if (out_free) begin
					out_q <= (it_q.cmd == CMD_LOOKUP && res_q.status == ST_DONE)
					         ? out_item_t'{status: res_q.status, chosen_server: srv_q,
					                       chosen_valid: 1'b1}
					         : res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/chr_checker.sv
module chr_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  chr_pkg::out_item_t  out_data
);
	import chr_pkg::*;

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an accepted item keeps the block busy in the cycle after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while item in flight");

	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.chosen_valid |-> out_data.status == ST_DONE)
		else $error("lookup answer with bad status");

	a_server_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.chosen_valid |-> out_data.chosen_server == '0)
		else $error("server set without answer");

endmodule

bind consistent_hash_ring_bounded_load chr_checker u_chr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### dv/tb_consistent_hash_ring_bounded_load.sv
module tb_consistent_hash_ring_bounded_load;
	import chr_pkg::*;

	localparam int STALL_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_idx = CFG_BALANCE;
	logic [CUM_W-1:0] cfg_data = '0;

	consistent_hash_ring_bounded_load u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor copy of the block state
	ring_entry_t ring_q[$];
	srv_rec_t srv_tab [SERVERS];
	logic [BF_W-1:0] bal_factor;
	logic [CUM_W-1:0] wsum_cfg;

	out_item_t result_q[$];
	int n_sent, n_checked, n_errors, n_lookups, n_skips, n_full, n_absent;
	int idle_cycles;
	bit no_idle;

	// bounded-load quota test for one server
	function automatic bit server_has_room(logic [SRV_W-1:0] srv, logic [LOAD_W-1:0] tload);
		longint unsigned w, wb, busy, tw, tot, q, r, slots;
		w    = srv_tab[srv].weight;
		wb   = srv_tab[srv].weight_before;
		busy = srv_tab[srv].busy;
		tw   = (wsum_cfg == 0) ? 1 : wsum_cfg;
		tot  = ((longint'(tload) + 1) * bal_factor + 99) / 100;
		q    = tot / tw;
		r    = tot % tw;
		slots = w * q + ((wb + w) * r) / tw - (wb * r) / tw;
		if (slots == 0)
			slots = 1;
		return busy < slots;
	endfunction

	// advance the predicted ring and server table by one item, return its result
	function automatic out_item_t ring_apply(in_item_t it);
		out_item_t res;
		ring_entry_t ent;
		int pos, nx, pv, idx, wraps, cnt;
		logic [KEY_W-1:0] dp, dn;
		logic [SRV_W-1:0] srv;
		res = '0;
		cnt = ring_q.size();
		case (it.cmd)
			CMD_INSERT: begin
				if (cnt >= RING_ENTRIES) begin
					res.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < cnt && ring_q[pos].key <= it.key)
						pos++;
					ent.key = it.key;
					ent.owner = it.server_id;
					ring_q.insert(pos, ent);
				end
			end
			CMD_REMOVE: begin
				pos = 0;
				while (pos < cnt && ring_q[pos].key != it.key)
					pos++;
				if (pos >= cnt)
					res.status = ST_ABSENT;
				else
					ring_q.delete(pos);
			end
			CMD_RECORD: begin
				srv_tab[it.server_id].weight = it.weight;
				srv_tab[it.server_id].weight_before = it.weight_before;
				srv_tab[it.server_id].busy = it.server_load;
			end
			default: begin
				if (cnt == 0) begin
					res.status = ST_ABSENT;
				end else begin
					nx = 0;
					while (nx < cnt && ring_q[nx].key < it.key)
						nx++;
					if (nx >= cnt)
						nx = 0;
					pv = (nx == 0) ? cnt - 1 : nx - 1;
					dp = it.key - ring_q[pv].key;
					dn = ring_q[nx].key - it.key;
					idx = (dp <= dn) ? pv : nx;
					srv = ring_q[idx].owner;
					wraps = 0;
					while ((it.avoid_enable && srv == it.avoid_server) ||
					       (bal_factor != 0 && !server_has_room(srv, it.total_load))) begin
						idx++;
						n_skips++;
						if (idx >= cnt) begin
							idx = 0;
							wraps++;
							if (wraps > 1)
								break;
						end
						srv = ring_q[idx].owner;
					end
					res.chosen_server = srv;
					res.chosen_valid = 1'b1;
					n_lookups++;
				end
			end
		endcase
		if (res.status == ST_FULL)
			n_full++;
		if (res.status == ST_ABSENT)
			n_absent++;
		return res;
	endfunction

	// drive one item, with an occasional idle burst ahead of it
	task automatic send_item(in_item_t it);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		result_q.push_back(ring_apply(it));
		n_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (result_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(logic idx, logic [CUM_W-1:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_BALANCE)
			bal_factor = val[BF_W-1:0];
		else
			wsum_cfg = val;
	endtask

	function automatic in_item_t mk_item(logic [1:0] c, logic [KEY_W-1:0] k,
	                                      logic [SRV_W-1:0] sid);
		in_item_t it;
		it = '0;
		it.cmd = c;
		it.key = k;
		it.server_id = sid;
		return it;
	endfunction

	task automatic do_record(logic [SRV_W-1:0] sid, logic [WGT_W-1:0] w,
	                         logic [CUM_W-1:0] wb, logic [LOAD_W-1:0] ld);
		in_item_t it;
		it = mk_item(CMD_RECORD, $urandom, sid);
		it.weight = w;
		it.weight_before = wb;
		it.server_load = ld;
		send_item(it);
	endtask

	task automatic do_lookup(logic [KEY_W-1:0] h, logic av_en, logic [SRV_W-1:0] av,
	                         logic [LOAD_W-1:0] tl);
		in_item_t it;
		it = mk_item(CMD_LOOKUP, h, 6'($urandom));
		it.avoid_enable = av_en;
		it.avoid_server = av;
		it.total_load = tl;
		send_item(it);
	endtask

	// empty ring, absent key, extremes, duplicates, ties and wraps
	task automatic test_directed();
		do_lookup(32'h1234_5678, 1'b0, '0, '0);
		send_item(mk_item(CMD_REMOVE, 32'hdead_beef, 6'd0));
		send_item(mk_item(CMD_INSERT, 32'h0000_0000, 6'd1));
		send_item(mk_item(CMD_INSERT, 32'hffff_ffff, 6'd63));
		send_item(mk_item(CMD_INSERT, 32'h8000_0000, 6'd2));
		send_item(mk_item(CMD_INSERT, 32'h8000_0000, 6'd3));
		// tie between neighbors picks the earlier key
		do_lookup(32'h4000_0000, 1'b0, '0, '0);
		do_lookup(32'h8000_0000, 1'b0, '0, '0);
		// hash equal to the last key picks that key
		do_lookup(32'hffff_ffff, 1'b0, '0, '0);
		do_lookup(32'h0000_0001, 1'b1, 6'd1, '0);
		do_lookup(32'h7fff_fff0, 1'b1, 6'd2, 20'hfffff);
		// duplicate remove takes the first match
		send_item(mk_item(CMD_REMOVE, 32'h8000_0000, 6'd0));
		do_lookup(32'h8000_0000, 1'b0, '0, '0);
		do_record(6'd0, 12'hfff, 20'hfffff, 20'hfffff);
		do_record(6'd63, 12'd0, 20'd0, 20'd0);
		do_record(6'd1, 12'd5, 20'd0, 20'd0);
		do_record(6'd3, 12'd5, 20'd5, 20'd100);
		write_reg(CFG_BALANCE, 20'd100);
		write_reg(CFG_TOTAL_W, 20'd10);
		do_lookup(32'h7000_0000, 1'b0, '0, 20'd3);
		// every server saturated: walk gives up after the second wrap
		do_record(6'd1, 12'd0, 20'd0, 20'hfffff);
		do_record(6'd63, 12'd0, 20'd0, 20'hfffff);
		do_lookup(32'h9000_0000, 1'b1, 6'd3, 20'd0);
		write_reg(CFG_TOTAL_W, 20'd0);
		do_lookup(32'h1000_0000, 1'b0, '0, 20'hfffff);
	endtask

	// random phase: mostly commands on a small ring with a few busy servers
	task automatic test_random(int n);
		in_item_t it;
		int sel;
		for (int i = 0; i < n; i++) begin
			it = '0;
			it.key = $urandom;
			it.server_id = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
			it.weight = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 20));
			it.weight_before = ($urandom_range(0, 3) == 0) ? 20'($urandom)
			                                                : 20'($urandom_range(0, 100));
			it.server_load = ($urandom_range(0, 3) == 0) ? 20'($urandom)
			                                              : 20'($urandom_range(0, 40));
			it.avoid_server = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
			it.avoid_enable = 1'($urandom);
			it.total_load = ($urandom_range(0, 3) == 0) ? 20'($urandom)
			                                             : 20'($urandom_range(0, 200));
			sel = $urandom_range(0, 99);
			if (sel < 25 && ring_q.size() < 40)
				it.cmd = CMD_INSERT;
			else if (sel < 40)
				it.cmd = CMD_REMOVE;
			else if (sel < 55)
				it.cmd = CMD_RECORD;
			else
				it.cmd = CMD_LOOKUP;
			// removes mostly hit a key present on the ring
			if (it.cmd == CMD_REMOVE && ring_q.size() != 0 && $urandom_range(0, 4) != 0)
				it.key = ring_q[$urandom_range(0, ring_q.size() - 1)].key;
			send_item(it);
		end
	endtask

	// result stall bursts
	int ostall_left = 0;
	always @(negedge clk) begin
		if (ostall_left > 0) begin
			ostall_left--;
			out_stall = 1'b1;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			ostall_left = $urandom_range(0, 5);
			out_stall = 1'b1;
		end else begin
			out_stall = 1'b0;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				want = result_q.pop_front();
				n_checked++;
				if (out_data.status !== want.status ||
				    out_data.chosen_server !== want.chosen_server ||
				    out_data.chosen_valid !== want.chosen_valid) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch at result %0d: expected %p got %p",
						         n_checked, want, out_data);
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		bal_factor = '0;
		wsum_cfg = 20'd1;
		for (int s = 0; s < SERVERS; s++)
			srv_tab[s] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_reg(CFG_BALANCE, 20'd0);
		write_reg(CFG_TOTAL_W, 20'd1);
		test_random(140);
		write_reg(CFG_BALANCE, 20'd150);
		write_reg(CFG_TOTAL_W, 20'd50);
		test_random(140);
		write_reg(CFG_BALANCE, 20'h0ffff);
		write_reg(CFG_TOTAL_W, 20'hfffff);
		test_random(140);
		write_reg(CFG_BALANCE, 20'($urandom_range(1, 400)));
		write_reg(CFG_TOTAL_W, 20'($urandom_range(1, 300)));
		test_random(140);
		// last stretch runs with no idling on either side
		no_idle = 1'b1;
		write_reg(CFG_BALANCE, 20'd100);
		write_reg(CFG_TOTAL_W, 20'd0);
		test_random(140);

		drain();
		repeat (50) @(posedge clk);
		$display("sent %0d items, checked %0d results, %0d lookups with %0d skip steps",
		         n_sent, n_checked, n_lookups, n_skips);
		$display("ring-full refusals %0d, empty-ring or absent-key results %0d",
		         n_full, n_absent);
		if (n_errors == 0 && result_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
